// ===== rtl/oversampled_soft_uart_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the oversampled soft UART core
// Implication checks, same cycle and next cycle, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef OVERSAMPLED_SOFT_UART_CORE_ASSERT_SVH
`define OVERSAMPLED_SOFT_UART_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define OSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define OSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OSU_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define OSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/osu_pkg.sv =====
// ----------------------------------------------------------------------------
// osu_pkg
// Constants, widths and result types of the oversampled soft UART.
// ----------------------------------------------------------------------------
package osu_pkg;

  localparam int TICKS_PER_BIT = 3;   // 3..16
  localparam int DATA_BITS     = 8;   // 5..8
  localparam int BYTE_W        = 8;

  localparam int FIRST_SAMPLE  = TICKS_PER_BIT + TICKS_PER_BIT / 2;
  localparam int FRAME_BITS    = DATA_BITS + 1;   // data bits plus stop slot

  localparam int RX_CNT_W      = $clog2(FIRST_SAMPLE + 1);
  localparam int PHASE_W       = $clog2(TICKS_PER_BIT + 1);
  localparam int BITS_W        = $clog2(FRAME_BITS + 1);

  typedef struct packed {
    logic              full;
    logic [BYTE_W-1:0] data;
  } rx_res_t;

  typedef struct packed {
    logic line;
    logic idle;
    logic accepted;
  } tx_res_t;

  typedef struct packed {
    tx_res_t tx;
    rx_res_t rx;
  } result_t;

endpackage

// ===== rtl/osu_if.sv =====
// ----------------------------------------------------------------------------
// osu_item_if / osu_result_if
// Valid/ready channels for tick items and per-tick results.
// ----------------------------------------------------------------------------
interface osu_item_if;
  logic                       valid;
  logic                       ready;
  logic                       rx_line;
  logic                       send_request;
  logic [osu_pkg::BYTE_W-1:0] send_data;
  logic                       read_ack;

  modport source (output valid, rx_line, send_request, send_data, read_ack, input ready);
  modport sink   (input valid, rx_line, send_request, send_data, read_ack, output ready);
endinterface

interface osu_result_if;
  logic                       valid;
  logic                       ready;
  logic                       tx_line;
  logic                       tx_idle;
  logic                       send_accepted;
  logic                       rx_ready;
  logic [osu_pkg::BYTE_W-1:0] rx_data;

  modport source (output valid, tx_line, tx_idle, send_accepted, rx_ready, rx_data,
                  input ready);
  modport sink   (input valid, tx_line, tx_idle, send_accepted, rx_ready, rx_data,
                  output ready);
endinterface

// ===== rtl/osu_rx.sv =====
// ----------------------------------------------------------------------------
// osu_rx
// Receiver: start detect, mid-bit sampling, byte latch and ready flag.
// ----------------------------------------------------------------------------
`include "oversampled_soft_uart_core_assert.svh"

module osu_rx (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             rx_line,
  input  logic             read_ack,
  output osu_pkg::rx_res_t res
);

  logic                              busy, busy_next;
  logic [osu_pkg::RX_CNT_W-1:0]      cnt, cnt_next, cnt_dec;
  logic [osu_pkg::BITS_W-1:0]        left, left_next, left_dec;
  logic [osu_pkg::DATA_BITS-1:0]     shift, shift_next;
  logic [osu_pkg::DATA_BITS-1:0]     hold, hold_next;
  logic                              full, full_next;
  logic                              frame_end;

  assign cnt_dec   = cnt - osu_pkg::RX_CNT_W'(1);
  assign left_dec  = left - osu_pkg::BITS_W'(1);
  assign frame_end = busy && (cnt_dec == '0) && (left_dec == '0);

  always_comb begin
    busy_next  = busy;
    cnt_next   = cnt;
    left_next  = left;
    shift_next = shift;
    hold_next  = hold;
    full_next  = full & ~read_ack;   // ack lands before the tick
    if (busy) begin
      cnt_next = cnt_dec;
      if (cnt_dec == '0) begin
        cnt_next  = osu_pkg::RX_CNT_W'(osu_pkg::TICKS_PER_BIT);
        left_next = left_dec;
        if (frame_end) begin
          // stop slot: latch, no framing check
          hold_next = shift;
          busy_next = 1'b0;
          full_next = 1'b1;
        end else begin
          shift_next = {rx_line, shift[osu_pkg::DATA_BITS-1:1]};
        end
      end
    end else if (!rx_line) begin
      busy_next = 1'b1;
      cnt_next  = osu_pkg::RX_CNT_W'(osu_pkg::FIRST_SAMPLE);
      left_next = osu_pkg::BITS_W'(osu_pkg::FRAME_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      left  <= '0;
      shift <= '0;
      hold  <= '0;
      full  <= 1'b0;
    end else if (step) begin
      busy  <= busy_next;
      cnt   <= cnt_next;
      left  <= left_next;
      shift <= shift_next;
      hold  <= hold_next;
      full  <= full_next;
    end
  end

  assign res.full = full_next;
  assign res.data = osu_pkg::BYTE_W'(hold_next);

  `OSU_ASSERT_NOW(a_rx_busy_counts, clk, rst, busy, (cnt != '0) && (left != '0), "rx count zero")
  `OSU_ASSERT_NEXT(a_rx_full_on_done, clk, rst, step && frame_end, full && !busy, "rx byte lost")
  `OSU_ASSERT_NOW(a_rx_idle_left, clk, rst, !busy, left == '0, "rx bit count left while idle")

endmodule

// ===== rtl/osu_tx.sv =====
// ----------------------------------------------------------------------------
// osu_tx
// Transmitter: free-running bit phase and start/data/stop sequencing.
// ----------------------------------------------------------------------------
`include "oversampled_soft_uart_core_assert.svh"

module osu_tx (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       send_request,
  input  logic [osu_pkg::BYTE_W-1:0] send_data,
  output osu_pkg::tx_res_t           res
);

  logic                          busy, busy_next, busy_a;
  logic                          done, done_next;
  logic [osu_pkg::PHASE_W-1:0]   phase, phase_next, phase_dec;
  logic [osu_pkg::BITS_W-1:0]    left, left_next, left_dec;
  logic [osu_pkg::DATA_BITS-1:0] hold, hold_next;
  logic [osu_pkg::DATA_BITS-1:0] shift, shift_next;
  logic                          level, level_next;
  logic                          accepted;

  assign accepted  = send_request & done;
  assign busy_a    = busy | accepted;
  assign phase_dec = phase - osu_pkg::PHASE_W'(1);
  assign left_dec  = left - osu_pkg::BITS_W'(1);

  always_comb begin
    busy_next  = busy_a;
    done_next  = done & ~accepted;
    hold_next  = accepted ? send_data[osu_pkg::DATA_BITS-1:0] : hold;
    phase_next = phase_dec;
    left_next  = left;
    shift_next = shift;
    level_next = level;
    if (phase_dec == '0) begin
      phase_next = osu_pkg::PHASE_W'(osu_pkg::TICKS_PER_BIT);
      if (busy_a) begin
        if (left == '0) begin
          // start bit
          level_next = 1'b0;
          shift_next = hold_next;
          left_next  = osu_pkg::BITS_W'(osu_pkg::FRAME_BITS);
        end else begin
          shift_next = shift >> 1;
          left_next  = left_dec;
          if (left_dec == '0) begin
            // stop bit, frame done
            level_next = 1'b1;
            busy_next  = 1'b0;
            done_next  = 1'b1;
          end else begin
            level_next = shift[0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b1;
      phase <= osu_pkg::PHASE_W'(osu_pkg::TICKS_PER_BIT);
      left  <= '0;
      hold  <= '0;
      shift <= '0;
      level <= 1'b1;
    end else if (step) begin
      busy  <= busy_next;
      done  <= done_next;
      phase <= phase_next;
      left  <= left_next;
      hold  <= hold_next;
      shift <= shift_next;
      level <= level_next;
    end
  end

  assign res.line     = level_next;
  assign res.idle     = done_next;
  assign res.accepted = accepted;

  `OSU_ASSERT_NOW(a_tx_busy_xor_done, clk, rst, 1'b1, busy != done, "tx busy and done disagree")
  `OSU_ASSERT_NOW(a_tx_phase_nonzero, clk, rst, 1'b1, phase != '0, "tx phase reached zero")
  `OSU_ASSERT_NOW(a_tx_idle_level, clk, rst, done, level, "tx line low while done")

endmodule

// ===== rtl/osu_out_buf.sv =====
// ----------------------------------------------------------------------------
// osu_out_buf
// Result register plus skid stage; the tick stalls only once the skid is full.
// ----------------------------------------------------------------------------
`include "oversampled_soft_uart_core_assert.svh"

module osu_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  osu_pkg::result_t     in_data,
  osu_result_if.source         result
);

  logic             out_valid;
  osu_pkg::result_t out_data;
  logic             skid_valid;
  osu_pkg::result_t skid_data;
  logic             in_fire;
  logic             out_stall;

  assign in_ready  = ~skid_valid;
  assign in_fire   = in_valid & in_ready;
  assign out_stall = out_valid & ~result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_stall) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

  assign result.valid         = out_valid;
  assign result.tx_line       = out_data.tx.line;
  assign result.tx_idle       = out_data.tx.idle;
  assign result.send_accepted = out_data.tx.accepted;
  assign result.rx_ready      = out_data.rx.full;
  assign result.rx_data       = out_data.rx.data;

  `OSU_ASSERT_NOW(a_skid_implies_out, clk, rst, skid_valid, out_valid, "skid full with empty output")
  `OSU_ASSERT_NEXT(a_stall_fills_skid, clk, rst, out_stall && in_fire, skid_valid, "transfer lost")
  `OSU_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid, "stalled output dropped")

endmodule

// ===== rtl/oversampled_soft_uart_core.sv =====
// ----------------------------------------------------------------------------
// oversampled_soft_uart_core
// 8N1 UART transmitter and receiver stepped by one oversampling tick per item.
// ----------------------------------------------------------------------------
// A tick's result is registered, or held in the skid while the output stalls.
// Throughput: one tick per cycle while the skid is empty; the single-pass
//   next-state logic in osu_rx and osu_tx is the only path, and the skid
//   stage takes a result in a stall (input ready drops only while it is full).
// Reset (rst, synchronous): receiver idle and empty, transmitter done with the
//   line high, bit phase at TICKS_PER_BIT, result buffer empty.

module oversampled_soft_uart_core (
  input  logic         clk,
  input  logic         rst,
  osu_item_if.sink     item,
  osu_result_if.source result
);

  // A tick advances the state only when its transfer is taken, so the
  // result buffer's readiness gates everything.
  logic             buf_ready;
  logic             step;
  osu_pkg::rx_res_t rx_res;
  osu_pkg::tx_res_t tx_res;
  osu_pkg::result_t res;

  assign item.ready = buf_ready;
  assign step       = item.valid & buf_ready;

  // Receiver: ack is applied ahead of the tick inside the unit.
  osu_rx u_rx (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_line  (item.rx_line),
    .read_ack (item.read_ack),
    .res      (rx_res)
  );

  // Transmitter: send request is taken only while the previous frame is done.
  osu_tx u_tx (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .send_request (item.send_request),
    .send_data    (item.send_data),
    .res          (tx_res)
  );

  // Post-tick values of both units form the result of this transfer.
  assign res.tx = tx_res;
  assign res.rx = rx_res;

  osu_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (buf_ready),
    .in_data  (res),
    .result   (result)
  );

endmodule
